FILE: design/s2cd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2cd_pkg: shared types and constants for the seconds-to-date converter
// Field widths, calendar constants, divisor seeds, sequencer states and the
// month length lookup.
// ----------------------------------------------------------------------------
package s2cd_pkg;

	// Last supported year; counts at or beyond its end are out of range
	localparam int MAX_YEAR = 9999;

	localparam int IN_W    = 39;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int WDAY_W  = 3;
	localparam int TOD_W   = 17;

	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;
	localparam int DAYS_PER_400Y = 146097;
	localparam int DAYS_PER_100Y = 36524;
	localparam int DAYS_PER_4Y   = 1461;
	localparam int DAYS_PER_YEAR = 365;

	// Quotient widths of each restoring division
	localparam int DAY_Q_W   = 23;
	localparam int N400_MAX  = (MAX_YEAR - 1) / 400;
	localparam int N400_W    = (N400_MAX > 0) ? $clog2(N400_MAX + 1) : 1;
	localparam int N100_W    = 2;
	localparam int N4_W      = 5;
	localparam int N1_W      = 2;
	localparam int CNT_W     = $clog2(DAY_Q_W);

	// First day beyond the last supported year
	localparam int DAYS_LIMIT = DAYS_PER_YEAR * MAX_YEAR + MAX_YEAR / 4
		- MAX_YEAR / 100 + MAX_YEAR / 400;

	// Divisors pre-shifted to the top quotient bit of their division, and the unshifted range limit
	localparam logic [IN_W-1:0] DVS_DAY   = IN_W'(SECS_PER_DAY) << (DAY_Q_W - 1);
	localparam logic [IN_W-1:0] DVS_LIMIT = IN_W'(DAYS_LIMIT);
	localparam logic [IN_W-1:0] DVS_400   = IN_W'(DAYS_PER_400Y) << (N400_W - 1);
	localparam logic [IN_W-1:0] DVS_100   = IN_W'(DAYS_PER_100Y) << (N100_W - 1);
	localparam logic [IN_W-1:0] DVS_4     = IN_W'(DAYS_PER_4Y) << (N4_W - 1);
	localparam logic [IN_W-1:0] DVS_1     = IN_W'(DAYS_PER_YEAR) << (N1_W - 1);
	localparam logic [IN_W-1:0] DVS_HOUR  = IN_W'(SECS_PER_HOUR) << (HOUR_W - 1);
	localparam logic [IN_W-1:0] DVS_MIN   = IN_W'(SECS_PER_MIN) << (MIN_W - 1);

	localparam logic [CNT_W-1:0] CNT_DAY  = CNT_W'(DAY_Q_W - 1);
	localparam logic [CNT_W-1:0] CNT_400  = CNT_W'(N400_W - 1);
	localparam logic [CNT_W-1:0] CNT_100  = CNT_W'(N100_W - 1);
	localparam logic [CNT_W-1:0] CNT_4    = CNT_W'(N4_W - 1);
	localparam logic [CNT_W-1:0] CNT_1    = CNT_W'(N1_W - 1);
	localparam logic [CNT_W-1:0] CNT_HOUR = CNT_W'(HOUR_W - 1);
	localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(MIN_W - 1);

	// Last slot of a 400-year cycle, of a century and of a four-year group
	localparam logic [N100_W-1:0] N100_LAST = N100_W'(3);
	localparam logic [N4_W-1:0]   N4_LAST   = N4_W'(24);
	localparam logic [N1_W-1:0]   N1_LAST   = N1_W'(3);

	localparam logic [WDAY_W:0]   DAYS_PER_WEEK = (WDAY_W + 1)'(7);
	// Day zero is a Monday
	localparam logic [WDAY_W-1:0] WD_INIT = WDAY_W'(1);
	// 2^k mod 7 for the top bit of the day quotient
	localparam logic [WDAY_W-1:0] M7_INIT = WDAY_W'(1 << ((DAY_Q_W - 1) % 3));

	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(0);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(3);
	localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(5);
	localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(8);
	localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(10);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(11);

	localparam int YEARS_400 = 400;
	localparam int YEARS_100 = 100;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DAYDIV,
		ST_RANGE,
		ST_Y400,
		ST_Y100,
		ST_Y4,
		ST_Y1,
		ST_MONTH,
		ST_HOUR,
		ST_MIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
		logic [WDAY_W-1:0]  wday;
		logic               oor;
	} res_t;

	// Length of month m (0 = January)
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		len = DAY_W'(31);
		case (m) inside
			MONTH_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_W'(30);
			default: len = DAY_W'(31);
		endcase
		return len;
	endfunction

endpackage

FILE: design/s2cd_subu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2cd_subu: shared compare-subtract unit
// Full-width subtract whose borrow gives the compare; every division step,
// the range check and the month walk go through it.
// ----------------------------------------------------------------------------
module s2cd_subu import s2cd_pkg::*; (
	input  logic [IN_W-1:0] a,
	input  logic [IN_W-1:0] b,
	output logic            ge,
	output logic [IN_W-1:0] diff
);

	logic borrow;

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = ~borrow;

endmodule

FILE: design/s2cd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2cd_core: sequencer and datapath of the seconds-to-date converter
// Runs restoring divisions (days, 400/100/4/1-year groups, hours, minutes),
// the range check and the month walk, all on one compare-subtract unit.
// ----------------------------------------------------------------------------
module s2cd_core import s2cd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic [IN_W-1:0] req_secs,
	output logic            res_valid,
	input  logic            res_ready,
	output res_t            res
);

	state_t state_q, state_d;

	logic [IN_W-1:0]    work_q, dvs_q, diff, work_nxt;
	logic               ge;
	logic [DAY_Q_W-1:0] quot_q, quot_nxt;
	logic [CNT_W-1:0]   cnt_q;
	logic               last_step;
	logic [TOD_W-1:0]   tod_q;
	logic [WDAY_W-1:0]  wd_q, m7_q, wd_nxt;
	logic [WDAY_W:0]    wd_sum;
	logic [N400_W-1:0]  n400_q;
	logic [N100_W-1:0]  n100_q;
	logic [N4_W-1:0]    n4_q;
	logic [N1_W-1:0]    n1_q;
	logic               leap_q, leap_nxt;
	logic [MONTH_W-1:0] month_q, month_inc;
	logic               month_go;
	logic [DAY_W-1:0]   day_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [MIN_W-1:0]   minute_q;
	logic [SEC_W-1:0]   second_q;
	logic               oor_q;
	logic [YEAR_W+1:0]  year_sum;

	s2cd_subu u_subu (
		.a    (work_q),
		.b    (dvs_q),
		.ge   (ge),
		.diff (diff)
	);

	assign work_nxt  = ge ? diff : work_q;
	assign quot_nxt  = {quot_q[DAY_Q_W-2:0], ge};
	assign last_step = (cnt_q == '0);
	assign month_inc = MONTH_W'(month_q + 1'b1);
	assign month_go  = ge && (month_q != MONTH_DEC);

	// Each set quotient bit of the day count adds 2^k mod 7
	assign wd_sum = {1'b0, wd_q} + {1'b0, m7_q};
	assign wd_nxt = (wd_sum >= DAYS_PER_WEEK) ? WDAY_W'(wd_sum - DAYS_PER_WEEK)
		: wd_sum[WDAY_W-1:0];

	// Leap: last year of a four-year group, unless a non-400 century end
	assign leap_nxt = (quot_nxt[N1_W-1:0] == N1_LAST)
		&& ((n4_q != N4_LAST) || (n100_q == N100_LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) state_d = ST_DAYDIV;
			end
			ST_DAYDIV: if (last_step) state_d = ST_RANGE;
			ST_RANGE:  state_d = ge ? ST_DONE : ST_Y400;
			ST_Y400:   if (last_step) state_d = ST_Y100;
			ST_Y100:   if (last_step) state_d = ST_Y4;
			ST_Y4:     if (last_step) state_d = ST_Y1;
			ST_Y1:     if (last_step) state_d = ST_MONTH;
			ST_MONTH:  if (!month_go) state_d = ST_HOUR;
			ST_HOUR:   if (last_step) state_d = ST_MIN;
			ST_MIN:    if (last_step) state_d = ST_DONE;
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					work_q <= req_secs;
					dvs_q  <= DVS_DAY;
					cnt_q  <= CNT_DAY;
					quot_q <= '0;
					wd_q   <= WD_INIT;
					m7_q   <= M7_INIT;
					oor_q  <= 1'b0;
				end
			end
			ST_DAYDIV: begin
				quot_q <= quot_nxt;
				cnt_q  <= cnt_q - 1'b1;
				m7_q   <= {m7_q[0], m7_q[WDAY_W-1:1]};
				if (ge) wd_q <= wd_nxt;
				if (last_step) begin
					// Remainder is the time of day; hold it for the end
					tod_q  <= work_nxt[TOD_W-1:0];
					work_q <= IN_W'(quot_nxt);
					dvs_q  <= DVS_LIMIT;
				end else begin
					work_q <= work_nxt;
					dvs_q  <= dvs_q >> 1;
				end
			end
			ST_RANGE: begin
				if (ge) begin
					oor_q <= 1'b1;
				end else begin
					dvs_q <= DVS_400;
					cnt_q <= CNT_400;
				end
			end
			ST_Y400, ST_Y100, ST_Y4, ST_Y1, ST_HOUR, ST_MIN: begin
				work_q <= work_nxt;
				quot_q <= quot_nxt;
				if (!last_step) begin
					dvs_q <= dvs_q >> 1;
					cnt_q <= cnt_q - 1'b1;
				end else begin
					case (state_q)
						ST_Y400: begin
							n400_q <= quot_nxt[N400_W-1:0];
							dvs_q  <= DVS_100;
							cnt_q  <= CNT_100;
						end
						ST_Y100: begin
							// Two quotient bits cap the century at 3
							n100_q <= quot_nxt[N100_W-1:0];
							dvs_q  <= DVS_4;
							cnt_q  <= CNT_4;
						end
						ST_Y4: begin
							n4_q  <= quot_nxt[N4_W-1:0];
							dvs_q <= DVS_1;
							cnt_q <= CNT_1;
						end
						ST_Y1: begin
							n1_q    <= quot_nxt[N1_W-1:0];
							leap_q  <= leap_nxt;
							month_q <= MONTH_JAN;
							dvs_q   <= IN_W'(month_len(MONTH_JAN, leap_nxt));
						end
						ST_HOUR: begin
							hour_q <= quot_nxt[HOUR_W-1:0];
							dvs_q  <= DVS_MIN;
							cnt_q  <= CNT_MIN;
						end
						ST_MIN: begin
							minute_q <= quot_nxt[MIN_W-1:0];
							second_q <= work_nxt[SEC_W-1:0];
						end
						default: ;
					endcase
				end
			end
			ST_MONTH: begin
				if (month_go) begin
					work_q  <= diff;
					month_q <= month_inc;
					dvs_q   <= IN_W'(month_len(month_inc, leap_q));
				end else begin
					day_q  <= DAY_W'(work_q[DAY_W-1:0] + 1'b1);
					work_q <= IN_W'(tod_q);
					dvs_q  <= DVS_HOUR;
					cnt_q  <= CNT_HOUR;
				end
			end
			default: ;
		endcase
	end

	assign year_sum = (YEAR_W + 2)'(n400_q) * (YEAR_W + 2)'(YEARS_400)
		+ (YEAR_W + 2)'(n100_q) * (YEAR_W + 2)'(YEARS_100)
		+ (YEAR_W + 2)'({n4_q, 2'b00})
		+ (YEAR_W + 2)'(n1_q)
		+ (YEAR_W + 2)'(1);

	always_comb begin
		res     = '0;
		res.oor = oor_q;
		if (!oor_q) begin
			res.year   = year_sum[YEAR_W-1:0];
			res.month  = month_inc;
			res.day    = day_q;
			res.hour   = hour_q;
			res.minute = minute_q;
			res.second = second_q;
			res.wday   = wd_q;
		end
	end

	a_start_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_DAYDIV))
		else $error("accepted transaction did not start the day division");

	a_wday_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (wd_q < WDAY_W'(7)))
		else $error("weekday accumulator left 0..6");

	a_time_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !oor_q) |-> ((hour_q < HOUR_W'(24)) && (minute_q < MIN_W'(60))
		&& (second_q < SEC_W'(60))))
		else $error("time of day out of range at result");

	a_date_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !oor_q) |-> ((day_q != '0) && (month_q <= MONTH_DEC)
		&& (day_q <= month_len(month_q, leap_q))))
		else $error("day of month out of range at result");

endmodule

FILE: design/seconds_to_calendar_date_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_top: seconds count to Gregorian date and time
// Converts seconds since 0001-01-01 00:00:00 to year, month, day, time of
// day and weekday, with an out-of-range flag past the last supported year.
// ----------------------------------------------------------------------------
// One transaction at a time: a count is taken when the converter is idle,
// and all of its steps run on the single compare-subtract unit, which does
// one quotient bit a cycle: the day count, a range check (an out-of-range
// count goes straight to the result), the 400/100/4/1-year groups, the
// month walk, then hours and minutes. The result then sits in an output
// register, so the next count is taken in the cycle after the previous
// result has moved there, even while out_ready is low.
module seconds_to_calendar_date_top import s2cd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [IN_W-1:0]    total_seconds,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [YEAR_W-1:0]  cal_year,
	output logic [MONTH_W-1:0] cal_month,
	output logic [DAY_W-1:0]   cal_day,
	output logic [HOUR_W-1:0]  clock_hour,
	output logic [MIN_W-1:0]   clock_minute,
	output logic [SEC_W-1:0]   clock_second,
	output logic [WDAY_W-1:0]  week_day,
	output logic               out_of_range
);

	logic res_valid, res_ready;
	res_t res, out_q;
	logic out_valid_q;

	s2cd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req_secs  (total_seconds),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Take a new result when the output register is empty or draining
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign cal_year     = out_q.year;
	assign cal_month    = out_q.month;
	assign cal_day      = out_q.day;
	assign clock_hour   = out_q.hour;
	assign clock_minute = out_q.minute;
	assign clock_second = out_q.second;
	assign week_day     = out_q.wday;
	assign out_of_range = out_q.oor;

endmodule

FILE: dv/s2cd_date_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2cd_date_checker: result predictor and scoreboard for the date converter
// Watches both channels. Each accepted count is turned into the expected
// calendar date and time, and each accepted result is compared field by
// field with the oldest expected date still waiting.
// ----------------------------------------------------------------------------
module s2cd_date_checker import s2cd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [IN_W-1:0]    total_seconds,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [YEAR_W-1:0]  cal_year,
	input  logic [MONTH_W-1:0] cal_month,
	input  logic [DAY_W-1:0]   cal_day,
	input  logic [HOUR_W-1:0]  clock_hour,
	input  logic [MIN_W-1:0]   clock_minute,
	input  logic [SEC_W-1:0]   clock_second,
	input  logic [WDAY_W-1:0]  week_day,
	input  logic               out_of_range,
	output int                 mismatches,
	output int                 pending,
	output int                 checked,
	output int                 beyond
);

	// Day number of 1 January of year MAX_YEAR+1
	localparam longint unsigned END_OF_CALENDAR = 365 * longint'(MAX_YEAR) + MAX_YEAR / 4
		- MAX_YEAR / 100 + MAX_YEAR / 400;

	res_t expected_dates[$];
	res_t want;
	res_t got;
	int   bad;

	function automatic res_t predict_date(input logic [IN_W-1:0] count);
		res_t                  r;
		longint unsigned       secs;
		longint unsigned       day_no;
		int unsigned           tod;
		int unsigned           left;
		int unsigned           yr;
		int unsigned           g400;
		int unsigned           g100;
		int unsigned           g4;
		int unsigned           g1;
		int unsigned           mlen;
		logic                  leap;
		logic [MONTH_W-1:0]    mo;
		r = '0;
		secs = count;
		day_no = secs / 86400;
		tod = int'(secs % 86400);
		if (day_no >= END_OF_CALENDAR) begin
			r.oor = 1'b1;
			return r;
		end
		g400 = int'(day_no / 146097);
		left = int'(day_no % 146097);
		// the last day of a 400-year cycle belongs to the fourth century
		g100 = left / 36524;
		if (g100 > 3)
			g100 = 3;
		left -= g100 * 36524;
		g4 = left / 1461;
		left = left % 1461;
		// likewise the leap day closing a four-year group
		g1 = left / 365;
		if (g1 > 3)
			g1 = 3;
		left -= g1 * 365;
		yr = 400 * g400 + 100 * g100 + 4 * g4 + g1 + 1;
		leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
		mo = MONTH_JAN;
		while (mo < MONTH_DEC) begin
			if (mo == MONTH_FEB)
				mlen = leap ? 29 : 28;
			else if (mo == MONTH_APR || mo == MONTH_JUN || mo == MONTH_SEP || mo == MONTH_NOV)
				mlen = 30;
			else
				mlen = 31;
			if (left < mlen)
				break;
			left -= mlen;
			mo++;
		end
		r.year   = YEAR_W'(yr);
		r.month  = MONTH_W'(mo + 1);
		r.day    = DAY_W'(left + 1);
		r.hour   = HOUR_W'(tod / 3600);
		r.minute = MIN_W'((tod % 3600) / 60);
		r.second = SEC_W'(tod % 60);
		r.wday   = WDAY_W'((day_no + 1) % 7);
		return r;
	endfunction

	function automatic int field_wrong(input string name, input int unsigned expv,
			input int unsigned actv);
		if (expv == actv)
			return 0;
		$error("%s: expected %0d, got %0d", name, expv, actv);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_dates.delete();
			mismatches <= 0;
			pending    <= 0;
			checked    <= 0;
			beyond     <= 0;
		end else begin
			// retire first: a result never belongs to a count taken at the same edge
			if (out_valid && out_ready) begin
				got = {cal_year, cal_month, cal_day, clock_hour, clock_minute,
					clock_second, week_day, out_of_range};
				if (expected_dates.size() == 0) begin
					$error("result with no conversion outstanding: year %0d month %0d day %0d",
						cal_year, cal_month, cal_day);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_dates.pop_front();
					bad = field_wrong("cal_year", want.year, got.year)
						+ field_wrong("cal_month", want.month, got.month)
						+ field_wrong("cal_day", want.day, got.day)
						+ field_wrong("clock_hour", want.hour, got.hour)
						+ field_wrong("clock_minute", want.minute, got.minute)
						+ field_wrong("clock_second", want.second, got.second)
						+ field_wrong("week_day", want.wday, got.wday)
						+ field_wrong("out_of_range", want.oor, got.oor);
					mismatches <= mismatches + bad;
					checked    <= checked + 1;
					if (want.oor)
						beyond <= beyond + 1;
				end
			end
			if (in_valid && in_ready)
				expected_dates.push_back(predict_date(total_seconds));
			pending <= expected_dates.size();
		end
	end

endmodule

FILE: dv/seconds_to_calendar_date_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_top_test: testbench for the seconds-to-date block
// Sends calendar corner cases, then random counts in bursts (nearly half of them dates
// built around month, leap and century edges), while the receiver stalls in
// phases. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_top_test;
	import s2cd_pkg::*;

	localparam int RANDOM_ITEMS = 730;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 80;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic [IN_W-1:0]    total_seconds = '0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic [YEAR_W-1:0]  cal_year;
	logic [MONTH_W-1:0] cal_month;
	logic [DAY_W-1:0]   cal_day;
	logic [HOUR_W-1:0]  clock_hour;
	logic [MIN_W-1:0]   clock_minute;
	logic [SEC_W-1:0]   clock_second;
	logic [WDAY_W-1:0]  week_day;
	logic               out_of_range;

	int mismatches;
	int pending;
	int checked;
	int beyond;
	int quiet_cycles = 0;
	int stall_left   = 0;
	int rx_cycle     = 0;

	always #5 clk = ~clk;

	seconds_to_calendar_date_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.total_seconds(total_seconds),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cal_year     (cal_year),
		.cal_month    (cal_month),
		.cal_day      (cal_day),
		.clock_hour   (clock_hour),
		.clock_minute (clock_minute),
		.clock_second (clock_second),
		.week_day     (week_day),
		.out_of_range (out_of_range)
	);

	s2cd_date_checker date_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.total_seconds(total_seconds),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cal_year     (cal_year),
		.cal_month    (cal_month),
		.cal_day      (cal_day),
		.clock_hour   (clock_hour),
		.clock_minute (clock_minute),
		.clock_second (clock_second),
		.week_day     (week_day),
		.out_of_range (out_of_range),
		.mismatches   (mismatches),
		.pending      (pending),
		.checked      (checked),
		.beyond       (beyond)
	);

	// Seconds count of a given year, day of year (0-based) and time of day
	function automatic longint unsigned secs_at(input int unsigned yr, input int unsigned doy,
			input int unsigned tod);
		longint unsigned past;
		past = yr - 1;
		return (365 * past + past / 4 - past / 100 + past / 400 + doy) * SECS_PER_DAY + tod;
	endfunction

	function automatic logic [IN_W-1:0] random_count(input longint unsigned first_oor);
		longint unsigned wide;
		int unsigned     kind;
		int unsigned     yr;
		int unsigned     doy;
		int unsigned     tod;
		kind = $urandom_range(0, 99);
		wide = {$urandom, $urandom};
		if (kind < 45) begin
			case ($urandom_range(0, 3))
				0: yr = $urandom_range(1, MAX_YEAR);
				1: yr = 4 * $urandom_range(1, MAX_YEAR / 4);
				2: yr = 100 * $urandom_range(1, MAX_YEAR / 100);
				default: yr = 400 * $urandom_range(1, MAX_YEAR / 400);
			endcase
			case ($urandom_range(0, 6))
				0: doy = 0;
				1: doy = 58;
				2: doy = 59;
				3: doy = 60;
				4: doy = 364;
				5: doy = 365;
				default: doy = $urandom_range(0, 364);
			endcase
			case ($urandom_range(0, 2))
				0: tod = 0;
				1: tod = SECS_PER_DAY - 1;
				default: tod = $urandom_range(0, SECS_PER_DAY - 1);
			endcase
			return IN_W'(secs_at(yr, doy, tod));
		end
		if (kind < 75)
			return IN_W'(wide % first_oor);
		if (kind < 90)
			return IN_W'(wide);
		if (kind < 95)
			return IN_W'(first_oor + $urandom_range(0, 3 * SECS_PER_DAY));
		return IN_W'(first_oor - 1 - $urandom_range(0, 3 * SECS_PER_DAY));
	endfunction

	// Present one count and hold it until the transaction completes
	task automatic send_count(input logic [IN_W-1:0] count);
		in_valid      <= 1'b1;
		total_seconds <= count;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Receiver: free-running, short frequent stalls, then rare long ones
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			case ((rx_cycle / 512) % 3)
				0: out_ready <= 1'b1;
				1: begin
					if ($urandom_range(0, 2) == 0) begin
						out_ready  <= 1'b0;
						stall_left <= $urandom_range(0, 3);
					end else begin
						out_ready <= 1'b1;
					end
				end
				default: begin
					if ($urandom_range(0, 15) == 0) begin
						out_ready  <= 1'b0;
						stall_left <= $urandom_range(4, 15);
					end else begin
						out_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [IN_W-1:0] corners[$];
		longint unsigned first_oor;
		int              sent;
		int              burst_left;
		first_oor = secs_at(MAX_YEAR + 1, 0, 0);
		corners.push_back('0);
		corners.push_back(IN_W'(SECS_PER_DAY - 1));
		corners.push_back(IN_W'(SECS_PER_DAY));
		corners.push_back(IN_W'(secs_at(1, 364, 43200)));
		// leap year: last days of February, the first of March and the final day of the year
		corners.push_back(IN_W'(secs_at(4, 58, 3661)));
		corners.push_back(IN_W'(secs_at(4, 59, 0)));
		corners.push_back(IN_W'(secs_at(4, 60, SECS_PER_DAY - 1)));
		corners.push_back(IN_W'(secs_at(4, 365, SECS_PER_DAY - 1)));
		// centuries that are not leap years and ones that are, then a plain leap year
		corners.push_back(IN_W'(secs_at(100, 58, 59)));
		corners.push_back(IN_W'(secs_at(100, 59, 60)));
		corners.push_back(IN_W'(secs_at(400, 59, 3599)));
		corners.push_back(IN_W'(secs_at(400, 365, SECS_PER_DAY - 1)));
		corners.push_back(IN_W'(secs_at(1900, 59, 0)));
		corners.push_back(IN_W'(secs_at(2000, 59, 45296)));
		corners.push_back(IN_W'(secs_at(2024, 59, 45296)));
		// last second of the calendar, first second past it, largest count, two bit patterns
		corners.push_back(IN_W'(first_oor - 1));
		corners.push_back(IN_W'(first_oor));
		corners.push_back('1);
		corners.push_back(IN_W'(39'h2A_AAAA_AAAA));
		corners.push_back(IN_W'(39'h55_5555_5555));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corners[i])
			send_count(corners[i]);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst_left = $urandom_range(1, 24);
			while (burst_left > 0 && sent < RANDOM_ITEMS) begin
				send_count(random_count(first_oor));
				burst_left--;
				sent++;
			end
			// skip the gap now and then so that bursts run together
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d conversions from %0d corner counts and %0d random ones; %0d past year %0d.",
			checked, corners.size(), RANDOM_ITEMS, beyond, MAX_YEAR);
		$display("Sender ran in bursts with random gaps; receiver cycled free, short and long stalls.");
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
design/s2cd_pkg.sv
design/s2cd_subu.sv
design/s2cd_core.sv
design/seconds_to_calendar_date_top.sv
dv/s2cd_date_checker.sv
dv/seconds_to_calendar_date_top_test.sv
